FILE: hw/rtl/quadratic_root_solver_assert.svh
// assertion macros shared by the checker
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// same-cycle implication, off during reset
`define QRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qrs check failed");

// next-cycle implication, off during reset
`define QRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qrs check failed");

`endif

FILE: hw/rtl/qrs_pkg.sv
package qrs_pkg;

  localparam int CB = 16;
  localparam int FB = 16;
  localparam int RW = 34;

  localparam int NP   = CB + 1 + FB;
  localparam int MSW  = 2 * CB + 2;
  localparam int REMW = NP + 3;
  localparam int NW   = NP + 2;
  localparam int QW   = NP + 1;
  localparam int DENW = CB + 2;
  localparam int DMW  = CB + 1;
  localparam int DRW  = CB + 3;
  localparam int DW   = 2 * CB + 3;

  localparam logic [2:0] K_ANY  = 3'd0;
  localparam logic [2:0] K_NONE = 3'd1;
  localparam logic [2:0] K_LIN  = 3'd2;
  localparam logic [2:0] K_REAL = 3'd3;
  localparam logic [2:0] K_CPLX = 3'd4;

  typedef struct packed {
    logic                   vld;
    logic [2:0]             kind;
    logic [MSW-1:0]         m;
    logic [NP-1:0]          root;
    logic [REMW-1:0]        rem;
    logic signed [NW-1:0]   num0;
    logic signed [DENW-1:0] den;
  } sq_t;

  typedef struct packed {
    logic           vld;
    logic [2:0]     kind;
    logic           neg1;
    logic           neg2;
    logic [QW-1:0]  n1;
    logic [QW-1:0]  n2;
    logic [QW-1:0]  q1;
    logic [QW-1:0]  q2;
    logic [DRW-1:0] r1;
    logic [DRW-1:0] r2;
    logic [DMW-1:0] dm;
  } dv_t;

  // one digit pair of the square root
  function automatic sq_t sq_step(sq_t x);
    sq_t y;
    logic [REMW-1:0] rsh;
    logic [REMW-1:0] trial;
    y = x;
    rsh = {x.rem[REMW-3:0], x.m[MSW-1:MSW-2]};
    trial = REMW'({x.root, 2'b01});
    y.m = {x.m[MSW-3:0], 2'b00};
    if (rsh >= trial) begin
      y.rem = rsh - trial;
      y.root = {x.root[NP-2:0], 1'b1};
    end else begin
      y.rem = rsh;
      y.root = {x.root[NP-2:0], 1'b0};
    end
    return y;
  endfunction

  // one quotient bit for both lanes
  function automatic dv_t dv_step(dv_t x);
    dv_t y;
    logic [DRW-1:0] t1;
    logic [DRW-1:0] t2;
    y = x;
    t1 = {x.r1[DRW-2:0], x.n1[QW-1]};
    t2 = {x.r2[DRW-2:0], x.n2[QW-1]};
    y.n1 = {x.n1[QW-2:0], 1'b0};
    y.n2 = {x.n2[QW-2:0], 1'b0};
    if (t1 >= DRW'(x.dm)) begin
      y.r1 = t1 - DRW'(x.dm);
      y.q1 = {x.q1[QW-2:0], 1'b1};
    end else begin
      y.r1 = t1;
      y.q1 = {x.q1[QW-2:0], 1'b0};
    end
    if (t2 >= DRW'(x.dm)) begin
      y.r2 = t2 - DRW'(x.dm);
      y.q2 = {x.q2[QW-2:0], 1'b1};
    end else begin
      y.r2 = t2;
      y.q2 = {x.q2[QW-2:0], 1'b0};
    end
    return y;
  endfunction

  // apply sign and clamp to the root range
  function automatic logic [RW-1:0] sat_root(logic neg, logic [QW-1:0] q);
    logic [QW:0] qx;
    logic [QW:0] lim;
    qx = {1'b0, q};
    lim = (QW+1)'(1) << (RW - 1);
    if (!neg) begin
      return (qx >= lim) ? {1'b0, {(RW-1){1'b1}}} : RW'(q);
    end
    return (qx > lim) ? {1'b1, {(RW-1){1'b0}}} : RW'(-qx);
  endfunction

endpackage

FILE: hw/rtl/quadratic_root_solver.sv
// done follows start through s1, sq[0..NP], dv[0..QW] and the output register
// throughput: one equation per cycle, busy stays low
// the depth is set by the 33-step square root and the 34-step divider pipelines
// rst (synchronous) clears valid flags and sq/dv stages; results never held off
module quadratic_root_solver (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [qrs_pkg::CB-1:0]  coef_a,
  input  logic signed [qrs_pkg::CB-1:0]  coef_b,
  input  logic signed [qrs_pkg::CB-1:0]  coef_c,
  output logic                           busy,
  output logic                           done,
  output logic [2:0]                     kind,
  output logic signed [qrs_pkg::RW-1:0]  root_one,
  output logic signed [qrs_pkg::RW-1:0]  root_two
);

  logic                             s1_vld;
  logic signed [qrs_pkg::CB-1:0]    s1_a, s1_b, s1_c;
  logic signed [2*qrs_pkg::CB-1:0]  s1_bb, s1_ac;

  logic signed [qrs_pkg::DW-1:0]    disc;
  logic [qrs_pkg::DW-1:0]           dabs;
  qrs_pkg::sq_t                     sq_next;
  qrs_pkg::sq_t                     sq [0:qrs_pkg::NP];

  logic signed [qrs_pkg::NW-1:0]    s_ext, n1, n2;
  logic                             dneg;
  qrs_pkg::dv_t                     dv_next;
  qrs_pkg::dv_t                     dv [0:qrs_pkg::QW];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start;
    end
    s1_a <= coef_a;
    s1_b <= coef_b;
    s1_c <= coef_c;
    s1_bb <= coef_b * coef_b;
    s1_ac <= coef_a * coef_c;
  end

  // discriminant and case split
  always_comb begin
    disc = qrs_pkg::DW'(s1_bb) - (qrs_pkg::DW'(s1_ac) <<< 2);
    dabs = disc[qrs_pkg::DW-1] ? -disc : disc;
    sq_next = '0;
    sq_next.vld = s1_vld;
    sq_next.m = qrs_pkg::MSW'(dabs);
    if (s1_a == '0) begin
      if (s1_b == '0) begin
        sq_next.kind = (s1_c == '0) ? qrs_pkg::K_ANY : qrs_pkg::K_NONE;
        sq_next.num0 = '0;
        sq_next.den = qrs_pkg::DENW'(1);
      end else begin
        sq_next.kind = qrs_pkg::K_LIN;
        sq_next.num0 = (-(qrs_pkg::NW'(s1_c))) <<< qrs_pkg::FB;
        sq_next.den = qrs_pkg::DENW'(s1_b);
      end
    end else begin
      sq_next.kind = disc[qrs_pkg::DW-1] ? qrs_pkg::K_CPLX : qrs_pkg::K_REAL;
      sq_next.num0 = (-(qrs_pkg::NW'(s1_b))) <<< qrs_pkg::FB;
      sq_next.den = qrs_pkg::DENW'(s1_a) <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0] <= '0;
    end else begin
      sq[0] <= sq_next;
    end
  end

  for (genvar i = 0; i < qrs_pkg::NP; i++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (rst) begin
        sq[i+1] <= '0;
      end else begin
        sq[i+1] <= qrs_pkg::sq_step(sq[i]);
      end
    end
  end

  // numerators, magnitudes and quotient signs
  always_comb begin
    s_ext = $signed({2'b00, sq[qrs_pkg::NP].root});
    case (sq[qrs_pkg::NP].kind)
      qrs_pkg::K_REAL: begin
        n1 = sq[qrs_pkg::NP].num0 + s_ext;
        n2 = sq[qrs_pkg::NP].num0 - s_ext;
      end
      qrs_pkg::K_CPLX: begin
        n1 = sq[qrs_pkg::NP].num0;
        n2 = s_ext;
      end
      default: begin
        n1 = sq[qrs_pkg::NP].num0;
        n2 = '0;
      end
    endcase
    dneg = sq[qrs_pkg::NP].den[qrs_pkg::DENW-1];
    dv_next = '0;
    dv_next.vld = sq[qrs_pkg::NP].vld;
    dv_next.kind = sq[qrs_pkg::NP].kind;
    dv_next.neg1 = n1[qrs_pkg::NW-1] ^ dneg;
    dv_next.neg2 = n2[qrs_pkg::NW-1] ^ dneg;
    dv_next.n1 = n1[qrs_pkg::NW-1] ? qrs_pkg::QW'(-n1) : qrs_pkg::QW'(n1);
    dv_next.n2 = n2[qrs_pkg::NW-1] ? qrs_pkg::QW'(-n2) : qrs_pkg::QW'(n2);
    dv_next.dm = dneg ? qrs_pkg::DMW'(-sq[qrs_pkg::NP].den)
                      : qrs_pkg::DMW'(sq[qrs_pkg::NP].den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= '0;
    end else begin
      dv[0] <= dv_next;
    end
  end

  for (genvar j = 0; j < qrs_pkg::QW; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= '0;
      end else begin
        dv[j+1] <= qrs_pkg::dv_step(dv[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[qrs_pkg::QW].vld;
    end
    kind <= dv[qrs_pkg::QW].kind;
    root_one <= qrs_pkg::sat_root(dv[qrs_pkg::QW].neg1, dv[qrs_pkg::QW].q1);
    root_two <= qrs_pkg::sat_root(dv[qrs_pkg::QW].neg2, dv[qrs_pkg::QW].q2);
  end

endmodule

FILE: hw/rtl/qrs_check.sv
`include "quadratic_root_solver_assert.svh"

module qrs_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic [2:0]                     kind,
  input logic signed [qrs_pkg::RW-1:0]  root_one,
  input logic signed [qrs_pkg::RW-1:0]  root_two
);

  // no transfer is ever refused
  `QRS_ASSERT_IMP(a_never_busy, start, !busy)

  `QRS_ASSERT_IMP(a_kind_range, done, kind == qrs_pkg::K_ANY || kind == qrs_pkg::K_NONE ||
    kind == qrs_pkg::K_LIN || kind == qrs_pkg::K_REAL || kind == qrs_pkg::K_CPLX)

  // degenerate cases carry zero roots
  `QRS_ASSERT_IMP(a_degen_zero, done && (kind == qrs_pkg::K_ANY || kind == qrs_pkg::K_NONE),
    root_one == '0 && root_two == '0)

  `QRS_ASSERT_IMP(a_lin_second, done && kind == qrs_pkg::K_LIN, root_two == '0)

endmodule

bind quadratic_root_solver qrs_check u_qrs_check (.*);
